// ===== hdl/sdepb_pkg.sv =====
// shared types, codes and sizes for the sorted double-ended priority buffer
package sdepb_pkg;

   localparam int AREA_SIZE_DEF = 16;
   localparam int KEY_W         = 32;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT  = 2'd0,
      CMD_POP_MIN = 2'd1,
      CMD_POP_MAX = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_FREE,
      ST_INS_HEAD,
      ST_WALK,
      ST_LINK_PREV,
      ST_LINK_NEXT,
      ST_RM_READ,
      ST_RM_FREE,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic                    start;
      logic [CMD_W-1:0]        cmd;
      logic signed [KEY_W-1:0] key;
      logic                    take;
   } seq_cmd_type;

   typedef struct packed {
      logic                    idle;
      logic                    done;
      logic signed [KEY_W-1:0] key_out;
      status_type              status;
   } seq_stat_type;

endpackage

// ===== hdl/sdepb_ram.sv =====
// simple dual-port memory with registered read data
module sdepb_ram
   import sdepb_pkg::*;
#(
   parameter int WIDTH = KEY_W,
   parameter int DEPTH = AREA_SIZE_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sdepb_seq.sv =====
// list sequencer: key and link memories, walk compare and pointer updates
module sdepb_seq
   import sdepb_pkg::*;
#(
   parameter int AREA_SIZE = AREA_SIZE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  seq_cmd_type                    ctl,
   output seq_stat_type                   stat,
   output logic [$clog2(AREA_SIZE+1)-1:0] occupied
);

   localparam int IDX_W  = $clog2(AREA_SIZE);
   localparam int LINK_W = IDX_W + 1;
   localparam int CNT_W  = $clog2(AREA_SIZE + 1);
   localparam logic [LINK_W-1:0] NULL_LINK = {LINK_W{1'b1}};

   function automatic logic is_cell(input logic [LINK_W-1:0] l);
      return l < LINK_W'(AREA_SIZE);
   endfunction

   seq_state_type state_ff, state_in;
   logic [IDX_W-1:0]        clr_ff, clr_in;
   logic [LINK_W-1:0]       head_ff, head_in;
   logic [LINK_W-1:0]       tail_ff, tail_in;
   logic [LINK_W-1:0]       free_ff, free_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]        cell_ff, cell_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic [LINK_W-1:0]       nxt_ff, nxt_in;
   logic signed [KEY_W-1:0] key_out_ff, key_out_in;
   status_type              status_ff, status_in;

   logic              key_we, nx_we, pv_we;
   logic [IDX_W-1:0]  key_wa, nx_wa, pv_wa;
   logic [IDX_W-1:0]  key_ra, nx_ra, pv_ra;
   logic [KEY_W-1:0]  key_wd, key_rd;
   logic [LINK_W-1:0] nx_wd, nx_rd, pv_wd, pv_rd;

   logic              full;
   logic [LINK_W-1:0] end_link;
   logic [IDX_W-1:0]  end_cell;
   logic [LINK_W-1:0] nb;

   sdepb_ram #(.WIDTH(KEY_W), .DEPTH(AREA_SIZE)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_wa),
      .wr_data (key_wd),
      .rd_addr (key_ra),
      .rd_data (key_rd)
   );

   sdepb_ram #(.WIDTH(LINK_W), .DEPTH(AREA_SIZE)) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_wa),
      .wr_data (nx_wd),
      .rd_addr (nx_ra),
      .rd_data (nx_rd)
   );

   sdepb_ram #(.WIDTH(LINK_W), .DEPTH(AREA_SIZE)) u_prev_ram (
      .clock   (clock),
      .wr_en   (pv_we),
      .wr_addr (pv_wa),
      .wr_data (pv_wd),
      .rd_addr (pv_ra),
      .rd_data (pv_rd)
   );

   assign full     = (count_ff >= CNT_W'(AREA_SIZE)) || !is_cell(free_ff);
   assign end_link = (ctl.cmd == CMD_POP_MIN) ? head_ff : tail_ff;
   assign end_cell = is_cell(end_link) ? end_link[IDX_W-1:0] : '0;
   assign nb       = (cmd_ff == CMD_POP_MIN) ? nx_rd : pv_rd;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IDX_W'(AREA_SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (ctl.start) begin
               if (ctl.cmd == CMD_INSERT) begin
                  state_in = full ? ST_FINISH : ST_INS_FREE;
               end else if (ctl.cmd == CMD_POP_MIN || ctl.cmd == CMD_POP_MAX) begin
                  state_in = (count_ff == '0) ? ST_FINISH : ST_RM_READ;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_INS_FREE: begin
            if (count_ff == CNT_W'(1) || !is_cell(head_ff)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_INS_HEAD;
            end
         end
         ST_INS_HEAD: begin
            if (key_ff < $signed(key_rd)) begin
               state_in = ST_LINK_NEXT;
            end else if (is_cell(nx_rd)) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_LINK_PREV;
            end
         end
         ST_WALK: begin
            if (!($signed(key_rd) < key_ff && is_cell(nx_rd))) begin
               state_in = ST_LINK_PREV;
            end
         end
         ST_LINK_PREV: state_in = ST_LINK_NEXT;
         ST_LINK_NEXT: state_in = ST_FINISH;
         ST_RM_READ:   state_in = ST_RM_FREE;
         ST_RM_FREE:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (ctl.take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_in     = clr_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      free_in    = free_ff;
      count_in   = count_ff;
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      cell_in    = cell_ff;
      pos_in     = pos_ff;
      nxt_in     = nxt_ff;
      key_out_in = key_out_ff;
      status_in  = status_ff;
      key_we     = 1'b0;
      key_wa     = '0;
      key_wd     = '0;
      key_ra     = '0;
      nx_we      = 1'b0;
      nx_wa      = '0;
      nx_wd      = '0;
      nx_ra      = '0;
      pv_we      = 1'b0;
      pv_wa      = '0;
      pv_wd      = '0;
      pv_ra      = '0;
      case (state_ff)
         ST_CLEAR: begin
            nx_we  = 1'b1;
            nx_wa  = clr_ff;
            nx_wd  = {1'b0, clr_ff} + LINK_W'(1);
            pv_we  = 1'b1;
            pv_wa  = clr_ff;
            pv_wd  = NULL_LINK;
            clr_in = clr_ff + IDX_W'(1);
         end
         ST_IDLE: begin
            cmd_in     = ctl.cmd;
            key_in     = ctl.key;
            key_out_in = '0;
            status_in  = STATUS_DONE;
            if (ctl.start) begin
               if (ctl.cmd == CMD_INSERT) begin
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     cell_in  = free_ff[IDX_W-1:0];
                     nx_ra    = free_ff[IDX_W-1:0];
                     key_we   = 1'b1;
                     key_wa   = free_ff[IDX_W-1:0];
                     key_wd   = ctl.key;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (ctl.cmd == CMD_POP_MIN || ctl.cmd == CMD_POP_MAX) begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     cell_in = end_cell;
                     key_ra  = end_cell;
                     nx_ra   = end_cell;
                     pv_ra   = end_cell;
                  end
               end
            end
         end
         ST_INS_FREE: begin
            free_in = nx_rd;
            if (count_ff == CNT_W'(1) || !is_cell(head_ff)) begin
               head_in = {1'b0, cell_ff};
               tail_in = {1'b0, cell_ff};
               nx_we   = 1'b1;
               nx_wa   = cell_ff;
               nx_wd   = NULL_LINK;
               pv_we   = 1'b1;
               pv_wa   = cell_ff;
               pv_wd   = NULL_LINK;
            end else begin
               key_ra = head_ff[IDX_W-1:0];
               nx_ra  = head_ff[IDX_W-1:0];
            end
         end
         ST_INS_HEAD: begin
            if (key_ff < $signed(key_rd)) begin
               pv_we   = 1'b1;
               pv_wa   = cell_ff;
               pv_wd   = NULL_LINK;
               nxt_in  = head_ff;
               head_in = {1'b0, cell_ff};
            end else begin
               pos_in = head_ff[IDX_W-1:0];
               nxt_in = nx_rd;
               key_ra = nx_rd[IDX_W-1:0];
               nx_ra  = nx_rd[IDX_W-1:0];
            end
         end
         ST_WALK: begin
            if ($signed(key_rd) < key_ff) begin
               pos_in = nxt_ff[IDX_W-1:0];
               nxt_in = nx_rd;
               key_ra = nx_rd[IDX_W-1:0];
               nx_ra  = nx_rd[IDX_W-1:0];
            end
         end
         ST_LINK_PREV: begin
            nx_we = 1'b1;
            nx_wa = pos_ff;
            nx_wd = {1'b0, cell_ff};
            pv_we = 1'b1;
            pv_wa = cell_ff;
            pv_wd = {1'b0, pos_ff};
         end
         ST_LINK_NEXT: begin
            nx_we = 1'b1;
            nx_wa = cell_ff;
            if (is_cell(nxt_ff)) begin
               nx_wd = nxt_ff;
               pv_we = 1'b1;
               pv_wa = nxt_ff[IDX_W-1:0];
               pv_wd = {1'b0, cell_ff};
            end else begin
               nx_wd   = NULL_LINK;
               tail_in = {1'b0, cell_ff};
            end
         end
         ST_RM_READ: begin
            key_out_in = $signed(key_rd);
            if (cmd_ff == CMD_POP_MIN) begin
               head_in = nb;
               if (is_cell(nb)) begin
                  pv_we = 1'b1;
                  pv_wa = nb[IDX_W-1:0];
                  pv_wd = NULL_LINK;
               end
            end else begin
               tail_in = nb;
               if (is_cell(nb)) begin
                  nx_we = 1'b1;
                  nx_wa = nb[IDX_W-1:0];
                  nx_wd = NULL_LINK;
               end
            end
            count_in = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               head_in = NULL_LINK;
               tail_in = NULL_LINK;
            end
         end
         ST_RM_FREE: begin
            nx_we   = 1'b1;
            nx_wa   = cell_ff;
            nx_wd   = free_ff;
            free_in = {1'b0, cell_ff};
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         head_ff  <= NULL_LINK;
         tail_ff  <= NULL_LINK;
         free_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         free_ff  <= free_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      cell_ff    <= cell_in;
      pos_ff     <= pos_in;
      nxt_ff     <= nxt_in;
      key_out_ff <= key_out_in;
      status_ff  <= status_in;
   end

   assign stat.idle    = (state_ff == ST_IDLE);
   assign stat.done    = (state_ff == ST_FINISH);
   assign stat.key_out = key_out_ff;
   assign stat.status  = status_ff;
   assign occupied     = count_ff;

endmodule

// ===== hdl/sorted_double_ended_priority_buffer_core.sv =====
// top level of the sorted double-ended priority buffer with its result register
// Keeps up to AREA_SIZE signed keys in ascending order as a doubly linked list in
// three single-port-read memories (keys, next links, prev links). An insert walks
// the list from the head, one cell per cycle through the key and next-link memories,
// and compares at most AREA_SIZE - 2 keys behind the head; an insert into an empty
// store needs no walk, nor does one in front of the head. After reset the link memories
// are cleared in a pass over all AREA_SIZE cells with req_tready low. A finished result
// waits in an output register while the next request is taken.
module sorted_double_ended_priority_buffer_core
   import sdepb_pkg::*;
#(
   parameter int AREA_SIZE = AREA_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [KEY_W-1:0]      req_tdata,   // key
   input  logic [CMD_W-1:0]      req_tuser,   // cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [((KEY_W+$clog2(AREA_SIZE+1)+7)/8)*8-1:0]
                                 rsp_tdata,   // key_out, occupied, zero pad
   output logic [STATUS_W-1:0]   rsp_tuser    // status
);

   localparam int CNT_W      = $clog2(AREA_SIZE + 1);
   localparam int RSP_DATA_W = ((KEY_W + CNT_W + 7) / 8) * 8;

   seq_cmd_type        ctl;
   seq_stat_type       stat;
   logic [CNT_W-1:0]   occupied;
   logic               load;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]   rsp_user_ff, rsp_user_in;

   sdepb_seq #(.AREA_SIZE(AREA_SIZE)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .stat     (stat),
      .occupied (occupied)
   );

   assign load       = stat.done && (!rsp_valid_ff || rsp_tready);
   assign req_tready = stat.idle;

   assign ctl.start = req_tvalid && stat.idle;
   assign ctl.cmd   = req_tuser;
   assign ctl.key   = $signed(req_tdata);
   assign ctl.take  = load;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({occupied, stat.key_out});
         rsp_user_in  = stat.status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== hdl/sdepb_checker.sv =====
// port-level checker for the sorted double-ended priority buffer and its bind
module sdepb_checker
   import sdepb_pkg::*;
#(
   parameter int AREA_SIZE = AREA_SIZE_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [((KEY_W+$clog2(AREA_SIZE+1)+7)/8)*8-1:0] rsp_tdata,
   input logic [STATUS_W-1:0] rsp_tuser
);

   localparam int CNT_W = $clog2(AREA_SIZE + 1);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // removal on empty store reports zero key and zero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_EMPTY |-> rsp_tdata[KEY_W+CNT_W-1:0] == '0)
      else $error("empty removal with nonzero fields");

   // dropped insert only when the store is full
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_FULL
         |-> rsp_tdata[KEY_W+CNT_W-1:KEY_W] == CNT_W'(AREA_SIZE)
             && rsp_tdata[KEY_W-1:0] == '0)
      else $error("dropped insert while not full");

   // count never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[KEY_W+CNT_W-1:KEY_W] <= CNT_W'(AREA_SIZE))
      else $error("occupied count above capacity");

endmodule

bind sorted_double_ended_priority_buffer_core sdepb_checker #(.AREA_SIZE(AREA_SIZE)) u_checker (.*);

// ===== sim/tb.sv =====
// testbench for the sorted double-ended priority buffer: directed and random requests
`timescale 1ns / 1ps

module tb;
   import sdepb_pkg::*;

   localparam int OCC_W = $clog2(AREA_SIZE_DEF + 1);
   localparam int RSP_W = ((KEY_W + OCC_W + 7) / 8) * 8;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic signed [KEY_W-1:0] key_out;
      status_type              status;
      logic [OCC_W-1:0]        occupied;
   } buffer_reply_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [KEY_W-1:0]    req_tdata = '0;    // key
   logic [CMD_W-1:0]    req_tuser = '0;    // cmd
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;         // key_out, occupied, zero pad
   logic [STATUS_W-1:0] rsp_tuser;         // status

   logic signed [KEY_W-1:0] sorted_keys[$];
   buffer_reply_type        awaited_replies[$];
   int                      error_count = 0;
   int                      rsp_hold_cycles = 0;
   bit                      req_gaps_on = 1'b1;
   bit                      rsp_stalls_on = 1'b1;

   sorted_double_ended_priority_buffer_core #(
      .AREA_SIZE(AREA_SIZE_DEF)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic void predict_buffer_op(input logic [CMD_W-1:0] cmd,
                                             input logic signed [KEY_W-1:0] key);
      buffer_reply_type reply;
      int               slot;
      reply.key_out = '0;
      reply.status  = STATUS_DONE;
      case (cmd)
         CMD_INSERT: begin
            if (sorted_keys.size() >= AREA_SIZE_DEF) begin
               reply.status = STATUS_FULL;
            end else begin
               slot = sorted_keys.size();
               for (int i = 0; i < sorted_keys.size(); i++) begin
                  if (sorted_keys[i] >= key) begin
                     slot = i;
                     break;
                  end
               end
               sorted_keys.insert(slot, key);
            end
         end
         CMD_POP_MIN, CMD_POP_MAX: begin
            if (sorted_keys.size() == 0) begin
               reply.status = STATUS_EMPTY;
            end else if (cmd == CMD_POP_MIN) begin
               reply.key_out = sorted_keys.pop_front();
            end else begin
               reply.key_out = sorted_keys.pop_back();
            end
         end
         default: begin
         end
      endcase
      reply.occupied = OCC_W'(sorted_keys.size());
      awaited_replies.push_back(reply);
   endfunction

   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic signed [KEY_W-1:0] key);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = key;
      req_tuser  = cmd;
      do @(posedge clock); while (!req_tready);
      predict_buffer_op(cmd, key);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   task automatic check_reply();
      buffer_reply_type        want;
      logic signed [KEY_W-1:0] got_key;
      logic [OCC_W-1:0]        got_occupied;
      got_key      = rsp_tdata[KEY_W-1:0];
      got_occupied = rsp_tdata[KEY_W +: OCC_W];
      if (awaited_replies.size() == 0) begin
         $error("response with no request pending: key_out %0d", got_key);
         error_count++;
         return;
      end
      want = awaited_replies.pop_front();
      if (got_key !== want.key_out) begin
         $error("key_out: expected %0d, actual %0d", want.key_out, got_key);
         error_count++;
      end
      if (rsp_tuser !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
         error_count++;
      end
      if (got_occupied !== want.occupied) begin
         $error("occupied: expected %0d, actual %0d", want.occupied, got_occupied);
         error_count++;
      end
   endtask

   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_tready = 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         stall = rsp_stalls_on ? $urandom_range(0, 15) : 0;
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid && rsp_hold_cycles == 0);
         if (rsp_tvalid) begin
            check_reply();
         end
      end
   end

   function automatic logic signed [KEY_W-1:0] draw_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom;
         5, 6, 7:       return $signed($urandom_range(0, 15)) - 8;
         default: begin
            case ($urandom_range(0, 3))
               0:       return KEY_MIN;
               1:       return KEY_MAX;
               2:       return '0;
               default: return -1;
            endcase
         end
      endcase
   endfunction

   task automatic test_empty_store();
      send_request(CMD_POP_MIN, KEY_MAX);
      send_request(CMD_POP_MAX, KEY_MIN);
      send_request(CMD_UNUSED, 32'sh5A5A_A5A5);
      wait_for_drain();
   endtask

   task automatic test_key_extremes();
      send_request(CMD_INSERT, KEY_MAX);
      send_request(CMD_INSERT, KEY_MIN);
      send_request(CMD_INSERT, 0);
      send_request(CMD_INSERT, -1);
      // same key as the head goes behind it
      send_request(CMD_INSERT, KEY_MIN);
      send_request(CMD_INSERT, 5);
      send_request(CMD_POP_MIN, 0);
      send_request(CMD_POP_MAX, 0);
      send_request(CMD_UNUSED, -1);
      wait_for_drain();
   endtask

   task automatic test_full_store();
      int fill;
      fill = AREA_SIZE_DEF - sorted_keys.size();
      // descending keys so each one lands directly behind the head
      for (int i = 0; i < fill; i++) begin
         send_request(CMD_INSERT, -100 - 7 * i);
      end
      send_request(CMD_INSERT, 42);
      send_request(CMD_UNUSED, 0);
      wait_for_drain();
   endtask

   task automatic test_backpressure();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      rsp_hold_cycles = 300;
      for (int i = 0; i < 24; i++) begin
         send_request((i % 3 == 0) ? CMD_POP_MAX : CMD_INSERT, draw_key());
      end
      wait_for_drain();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int               sent;
      int               seg_len;
      int               insert_pct;
      int               roll;
      logic [CMD_W-1:0] cmd;
      sent = 0;
      while (sent < 1550) begin
         seg_len = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0:       insert_pct = 75;
            1:       insert_pct = 25;
            default: insert_pct = 50;
         endcase
         req_gaps_on   = $urandom_range(0, 2) != 0;
         rsp_stalls_on = $urandom_range(0, 2) != 0;
         repeat (seg_len) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               cmd = CMD_UNUSED;
            end else if (roll < 3 + insert_pct * 97 / 100) begin
               cmd = CMD_INSERT;
            end else begin
               cmd = $urandom_range(0, 1) ? CMD_POP_MIN : CMD_POP_MAX;
            end
            send_request(cmd, (cmd == CMD_INSERT) ? draw_key() : $urandom);
            sent++;
         end
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_empty_store();
      test_key_extremes();
      test_full_store();
      test_backpressure();
      test_random_traffic();
      repeat (40) @(posedge clock);
      if (error_count == 0 && awaited_replies.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
